[rtl/core/adc_ema_then_window_average_top_macros.svh]
// Assertion macros shared by the block's RTL files.
// Expects aclk and aresetn in the scope of each use; NO_ASSERTIONS removes them.
`ifndef ADC_EMA_THEN_WINDOW_AVERAGE_TOP_MACROS_SVH
`define ADC_EMA_THEN_WINDOW_AVERAGE_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

`define AEWA_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

`define AEWA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define AEWA_ASSERT_IMP(label, ante, cons)

`define AEWA_ASSERT_NEXT(label, ante, cons)

`endif

`endif

[rtl/core/aewa_pkg.sv]
// Shared types and constants for the smoothing and window average block.
// No dependencies.
package aewa_pkg;

    localparam int FACTOR_BITS = 8;
    localparam int DIVR_BITS   = 8;

    localparam logic [FACTOR_BITS-1:0] FACTOR_RESET = 8'd5;

    typedef struct packed {
        logic busy;
        logic done;
    } aewa_div_stat_t;

endpackage

[rtl/core/aewa_div.sv]
// Shared restoring divider, one quotient bit per cycle.
// Depends on aewa_pkg; the high part of the numerator must be below the divisor.
`include "adc_ema_then_window_average_top_macros.svh"

module aewa_div #(
    parameter int LO_BITS = 12
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   start,
    input  logic [aewa_pkg::DIVR_BITS+LO_BITS-1:0] numer,
    input  logic [aewa_pkg::DIVR_BITS-1:0]         divisor,
    output logic [LO_BITS-1:0]                     quot,
    output aewa_pkg::aewa_div_stat_t               stat
);
    import aewa_pkg::*;

    localparam int NUM_BITS = DIVR_BITS + LO_BITS;
    localparam int CNT_BITS = $clog2(LO_BITS);
    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(LO_BITS - 1);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic [LO_BITS-1:0]   work_reg, work_next;
    logic [DIVR_BITS-1:0] rem_reg, rem_next;
    logic [DIVR_BITS-1:0] den_reg, den_next;
    logic [DIVR_BITS:0]   shifted;
    logic [DIVR_BITS:0]   diff;
    logic                 ge;

    assign shifted = {rem_reg, work_reg[LO_BITS-1]};
    assign diff    = shifted - {1'b0, den_reg};
    assign ge      = shifted >= {1'b0, den_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        work_next = work_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = numer[NUM_BITS-1:LO_BITS];
            work_next = numer[LO_BITS-1:0];
            den_next  = divisor;
        end else if (busy_reg) begin
            rem_next  = ge ? diff[DIVR_BITS-1:0] : shifted[DIVR_BITS-1:0];
            work_next = {work_reg[LO_BITS-2:0], ge};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        work_reg <= work_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
    end

    assign quot      = work_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

    `AEWA_ASSERT_IMP(a_div_hi_below_den, start, numer[NUM_BITS-1:LO_BITS] < divisor)
    `AEWA_ASSERT_IMP(a_div_no_restart, start, !busy_reg)
    `AEWA_ASSERT_NEXT(a_div_done_ends_busy, done_next, !busy_reg)

endmodule

[rtl/core/adc_ema_then_window_average_top.sv]
// Channel    Dir  Handshake               Payload
// s_         in   s_tvalid / s_tready     s_tdata: sample
// m_         out  m_tvalid / m_tready     m_tdata: window_mean, smoothed_value
// cfg_       in   cfg_valid / cfg_ready   cfg_data: smoothing_factor
//
// Each item runs SMOOTH_ROUNDS smoothing rounds, each a multiply and a division
// on the shared bit-serial divider, then a window update and the mean; the first
// item after reset fills the whole window memory with its smoothed value instead.
// s_tready is high only while idle; a result waits in the output register, and
// the next item stalls at its end only if that result is still not taken.
// Synchronous active-low reset; cfg_ready is always high.
// Depends on aewa_pkg, aewa_div and the assertion macro header.
`include "adc_ema_then_window_average_top_macros.svh"

module adc_ema_then_window_average_top #(
    parameter int WINDOW_DEPTH  = 16,
    parameter int SMOOTH_ROUNDS = 30,
    parameter int SAMPLE_BITS   = 12
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]          s_tdata,  // sample
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]        m_tdata,  // window_mean, smoothed_value
    input  logic                                      cfg_valid,
    output logic                                      cfg_ready,
    input  logic [aewa_pkg::FACTOR_BITS-1:0]          cfg_data  // smoothing_factor
);
    import aewa_pkg::*;

    localparam int S_BITS    = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int M_BITS    = ((2 * SAMPLE_BITS + 7) / 8) * 8;
    localparam int NUM_BITS  = DIVR_BITS + SAMPLE_BITS;
    localparam int SUM_BITS  = SAMPLE_BITS + $clog2(WINDOW_DEPTH);
    localparam int PTR_BITS  = $clog2(WINDOW_DEPTH);
    localparam int RND_BITS  = $clog2(SMOOTH_ROUNDS + 1);
    localparam int MUL_BITS  = SUM_BITS + 2;
    localparam int PROD_BITS = SUM_BITS + MUL_BITS;
    localparam int MEAN_SH   = SUM_BITS + PTR_BITS;
    localparam longint unsigned MEAN_MUL_W =
        ((64'd1 << MEAN_SH) + 64'(WINDOW_DEPTH) - 64'd1) / 64'(WINDOW_DEPTH);
    localparam logic [MUL_BITS-1:0]  MEAN_MUL = MUL_BITS'(MEAN_MUL_W);
    localparam logic [SUM_BITS-1:0]  DEPTH_W  = SUM_BITS'(WINDOW_DEPTH);
    localparam logic [SUM_BITS-1:0]  SUM_MAX  =
        SUM_BITS'(WINDOW_DEPTH * ((2 ** SAMPLE_BITS) - 1));
    localparam logic [PTR_BITS-1:0]  PTR_LAST = PTR_BITS'(WINDOW_DEPTH - 1);
    localparam logic [RND_BITS-1:0]  RND_LAST = RND_BITS'(SMOOTH_ROUNDS - 1);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_MUL   = 4'd1;
    localparam logic [3:0] ST_DIVS  = 4'd2;
    localparam logic [3:0] ST_DIVW  = 4'd3;
    localparam logic [3:0] ST_FILL  = 4'd4;
    localparam logic [3:0] ST_RD    = 4'd5;
    localparam logic [3:0] ST_UPD   = 4'd6;
    localparam logic [3:0] ST_MEANS = 4'd7;
    localparam logic [3:0] ST_DONE  = 4'd9;

    logic [3:0]             state_reg, state_next;
    logic [FACTOR_BITS-1:0] cfg_reg, cfg_next;
    logic [FACTOR_BITS-1:0] fac_reg, fac_next;
    logic [SAMPLE_BITS-1:0] sample_reg, sample_next;
    logic [SAMPLE_BITS-1:0] acc_reg, acc_next;
    logic [NUM_BITS-1:0]    prod_reg, prod_next;
    logic [RND_BITS-1:0]    rnd_reg, rnd_next;
    logic                   first_reg, first_next;
    logic [SUM_BITS-1:0]    sum_reg, sum_next;
    logic [PTR_BITS-1:0]    wptr_reg, wptr_next;
    logic [SAMPLE_BITS-1:0] mean_reg, mean_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [SAMPLE_BITS-1:0] m_mean_reg, m_mean_next;
    logic [SAMPLE_BITS-1:0] m_smooth_reg, m_smooth_next;

    logic [SAMPLE_BITS-1:0] win_mem [WINDOW_DEPTH];
    logic [SAMPLE_BITS-1:0] rd_data_reg;
    logic                   mem_we;

    logic                   div_start;
    logic [NUM_BITS-1:0]    div_numer;
    logic [DIVR_BITS-1:0]   div_den;
    logic [SAMPLE_BITS-1:0] div_quot;
    aewa_div_stat_t         div_stat;
    logic                   in_req;
    logic [PROD_BITS-1:0]   mean_prod;

    assign in_req    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    // window mean by reciprocal multiply, exact over the whole sum range
    assign mean_prod = PROD_BITS'(sum_reg) * PROD_BITS'(MEAN_MUL);

    aewa_div #(
        .LO_BITS (SAMPLE_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .numer   (div_numer),
        .divisor (div_den),
        .quot    (div_quot),
        .stat    (div_stat)
    );

    always_comb begin
        state_next    = state_reg;
        cfg_next      = cfg_reg;
        fac_next      = fac_reg;
        sample_next   = sample_reg;
        acc_next      = acc_reg;
        prod_next     = prod_reg;
        rnd_next      = rnd_reg;
        first_next    = first_reg;
        sum_next      = sum_reg;
        wptr_next     = wptr_reg;
        mean_next     = mean_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_mean_next   = m_mean_reg;
        m_smooth_next = m_smooth_reg;
        mem_we        = 1'b0;
        div_start     = 1'b0;
        div_numer     = prod_reg;
        div_den       = fac_reg;

        if (cfg_valid && cfg_ready) begin
            cfg_next = cfg_data;
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_req) begin
                    sample_next = s_tdata[SAMPLE_BITS-1:0];
                    fac_next    = (cfg_reg == '0) ? FACTOR_BITS'(1) : cfg_reg;
                    rnd_next    = '0;
                    state_next  = ST_MUL;
                end
            end
            ST_MUL: begin
                prod_next  = NUM_BITS'(acc_reg) * NUM_BITS'(fac_reg - 1'b1)
                             + NUM_BITS'(sample_reg);
                state_next = ST_DIVS;
            end
            ST_DIVS: begin
                div_start  = 1'b1;
                state_next = ST_DIVW;
            end
            ST_DIVW: begin
                if (div_stat.done) begin
                    acc_next = div_quot;
                    rnd_next = rnd_reg + 1'b1;
                    if (rnd_reg == RND_LAST) begin
                        state_next = first_reg ? ST_FILL : ST_RD;
                    end else begin
                        state_next = ST_MUL;
                    end
                end
            end
            ST_FILL: begin
                mem_we     = 1'b1;
                sum_next   = SUM_BITS'(acc_reg) * DEPTH_W;
                wptr_next  = (wptr_reg == PTR_LAST) ? '0 : wptr_reg + 1'b1;
                if (wptr_reg == PTR_LAST) begin
                    first_next = 1'b0;
                    state_next = ST_MEANS;
                end
            end
            ST_RD: begin
                state_next = ST_UPD;
            end
            ST_UPD: begin
                mem_we     = 1'b1;
                sum_next   = sum_reg - SUM_BITS'(rd_data_reg) + SUM_BITS'(acc_reg);
                wptr_next  = (wptr_reg == PTR_LAST) ? '0 : wptr_reg + 1'b1;
                state_next = ST_MEANS;
            end
            ST_MEANS: begin
                mean_next  = mean_prod[MEAN_SH +: SAMPLE_BITS];
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_mean_next   = mean_reg;
                    m_smooth_next = acc_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cfg_reg      <= FACTOR_RESET;
            acc_reg      <= '0;
            first_reg    <= 1'b1;
            sum_reg      <= '0;
            wptr_reg     <= '0;
            rnd_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cfg_reg      <= cfg_next;
            acc_reg      <= acc_next;
            first_reg    <= first_next;
            sum_reg      <= sum_next;
            wptr_reg     <= wptr_next;
            rnd_reg      <= rnd_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        fac_reg      <= fac_next;
        sample_reg   <= sample_next;
        prod_reg     <= prod_next;
        mean_reg     <= mean_next;
        m_mean_reg   <= m_mean_next;
        m_smooth_reg <= m_smooth_next;
    end

    // window memory: write at wptr, registered read of the oldest entry at wptr
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            win_mem[wptr_reg] <= acc_reg;
        end
        rd_data_reg <= win_mem[wptr_reg];
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_BITS'({m_smooth_reg, m_mean_reg});

    `AEWA_ASSERT_NEXT(a_busy_after_req, in_req, !s_tready)
    `AEWA_ASSERT_IMP(a_sum_in_range, state_reg == ST_MEANS, sum_reg <= SUM_MAX)
    `AEWA_ASSERT_IMP(a_load_from_done, $rose(m_tvalid_reg), $past(state_reg) == ST_DONE)
    `AEWA_ASSERT_IMP(a_div_idle_on_start, state_reg == ST_MUL || state_reg == ST_DIVS, !div_stat.busy)

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps
// Testbench for adc_ema_then_window_average_top: exponential smoothing then 16-deep window mean.
// Predicts each result in SystemVerilog and checks it against the m_ stream; needs aewa_pkg.
module tb;
    import aewa_pkg::*;

    localparam int WIN_DEPTH    = 16;
    localparam int EMA_ROUNDS   = 30;
    localparam int SMP_BITS     = 12;
    localparam int CYCLE_LIMIT  = 4000000;
    localparam int RAND_PER_SET = 88;

    typedef struct packed {
        logic [SMP_BITS-1:0] smoothed;
        logic [SMP_BITS-1:0] mean;
    } filt_result_t;

    logic                   aclk;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [15:0]            s_tdata   = '0;  // sample
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [23:0]            m_tdata;         // window_mean, smoothed_value
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [FACTOR_BITS-1:0] cfg_data  = '0;  // smoothing_factor

    adc_ema_then_window_average_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // filter model state
    logic [FACTOR_BITS-1:0] model_factor = FACTOR_RESET;
    logic [SMP_BITS-1:0]    ema_acc      = '0;
    logic [SMP_BITS-1:0]    window_hist[WIN_DEPTH];
    logic                   window_empty = 1'b1;
    int unsigned            window_total = 0;

    filt_result_t pending_results[$];
    int           mismatch_count = 0;
    int unsigned  cycle_count    = 0;
    int           send_idle_pct  = 0;
    int           recv_idle_pct  = 0;
    logic [SMP_BITS-1:0] held_sample = '0;

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic filt_result_t advance_filter(input logic [SMP_BITS-1:0] smp);
        int unsigned  div;
        int unsigned  acc;
        filt_result_t res;
        div = (model_factor == 0) ? 1 : model_factor;
        acc = ema_acc;
        for (int r = 0; r < EMA_ROUNDS; r++)
            acc = ((acc * (div - 1) + smp) / div) & 12'hFFF;
        ema_acc = acc[SMP_BITS-1:0];
        if (window_empty) begin
            for (int k = 0; k < WIN_DEPTH; k++)
                window_hist[k] = ema_acc;
            window_total = acc * WIN_DEPTH;
            window_empty = 1'b0;
        end else begin
            window_total = window_total - window_hist[WIN_DEPTH-1];
            for (int k = WIN_DEPTH - 1; k > 0; k--)
                window_hist[k] = window_hist[k-1];
            window_hist[0] = ema_acc;
            window_total = window_total + acc;
        end
        res.mean     = SMP_BITS'(window_total / WIN_DEPTH);
        res.smoothed = ema_acc;
        return res;
    endfunction

    always @(posedge aclk) begin
        filt_result_t want;
        filt_result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual mean %0d smoothed %0d",
                         $realtime, got.mean, got.smoothed);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (got.mean !== want.mean) begin
                    $display("%0t: window_mean expected %0d actual %0d",
                             $realtime, want.mean, got.mean);
                    mismatch_count++;
                end
                if (got.smoothed !== want.smoothed) begin
                    $display("%0t: smoothed_value expected %0d actual %0d",
                             $realtime, want.smoothed, got.smoothed);
                    mismatch_count++;
                end
            end
        end
    end

    // s_tvalid stays high across back-to-back requests; lowered only on a gap
    task automatic send_sample(input logic [SMP_BITS-1:0] smp);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'd0, smp};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_results.push_back(advance_filter(smp));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic write_factor(input logic [FACTOR_BITS-1:0] f);
        cfg_valid <= 1'b1;
        cfg_data  <= f;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        model_factor = f;
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [SMP_BITS-1:0] pick_sample();
        case ($urandom_range(9))
            0, 1: held_sample = $urandom_range(1) ? 12'hFFF : 12'h000;
            2, 3, 4: ;  // hold the level so the filter settles
            default: held_sample = SMP_BITS'($urandom_range(4095));
        endcase
        return held_sample;
    endfunction

    // first item fills the window; then extremes and bit patterns at reset factor
    task automatic test_directed_extremes();
        logic [SMP_BITS-1:0] pattern[$];
        pattern = '{12'hFFF, 12'hFFF, 12'h000, 12'h000, 12'hAAA, 12'h555, 12'hFFF,
                    12'h001, 12'h800, 12'h7FF, 12'h000, 12'hFFF, 12'hFFF, 12'hFFF};
        foreach (pattern[i]) send_sample(pattern[i]);
        wait_drained();
    endtask

    // factor one and zero pass the sample through; 255 tracks very slowly
    task automatic test_factor_edges();
        logic [FACTOR_BITS-1:0] edge_vals[$];
        edge_vals = '{8'd1, 8'd0, 8'd255};
        foreach (edge_vals[i]) begin
            write_factor(edge_vals[i]);
            send_sample(12'hFFF);
            send_sample(12'h000);
            send_sample(12'hA5A);
            send_sample(12'h5A5);
            send_sample(12'h000);
            send_sample(12'hFFF);
            wait_drained();
        end
    endtask

    task automatic test_random_stream(input int mode);
        logic [FACTOR_BITS-1:0] f;
        case (mode)
            0: begin send_idle_pct = 6;  recv_idle_pct = 62; end
            1: begin send_idle_pct = 62; recv_idle_pct = 6;  end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
        endcase
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: f = FACTOR_BITS'($urandom_range(2, 8));
                1: f = (mode == 0) ? 8'd255 : (mode == 1) ? 8'd0 : 8'd1;
                2: f = FACTOR_BITS'($urandom_range(0, 255));
                default: f = FACTOR_BITS'($urandom_range(1, 40));
            endcase
            write_factor(f);
            for (int n = 0; n < RAND_PER_SET; n++) send_sample(pick_sample());
            wait_drained();
        end
    endtask

    initial begin
        send_idle_pct = 6;
        recv_idle_pct = 62;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_extremes();
        test_factor_edges();
        test_random_stream(0);
        test_random_stream(1);
        test_random_stream(2);
        recv_idle_pct = 0;
        repeat (50) @(posedge aclk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

[files.f]
+incdir+rtl/core
rtl/core/aewa_pkg.sv
rtl/core/aewa_div.sv
rtl/core/adc_ema_then_window_average_top.sv
verif/tb.sv
